// ===== design/pmm_pkg.sv =====
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the pairwise mismatch matrix
// Field widths of the channels, call codes and the command opcode.
// ----------------------------------------------------------------------------
package pmm_pkg;

  // Channel field widths
  localparam int CALL_BITS = 3;
  localparam int ROW_BITS  = 6;
  localparam int CFG_BITS  = 7;
  localparam int OUT_BITS  = 32;

  // Individual count after reset
  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  // Lowest call code that means missing; codes above it are missing as well
  localparam logic [CALL_BITS-1:0] MISSING_CODE = 3'd4;

  // Item kinds on the input channel
  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Commands queued from the front end to the back end
  typedef enum logic {
    OP_CALL = 1'b0,
    OP_READ = 1'b1
  } op_t;

endpackage

// ===== design/pmm_if.sv =====
// ----------------------------------------------------------------------------
// pmm_if: channel interfaces of the pairwise mismatch matrix
// Input items, result items and the configuration write channel.
// ----------------------------------------------------------------------------
interface pmm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [pmm_pkg::CALL_BITS-1:0]  call_value;
  logic                           last_call;
  logic                           site_kept;
  logic [pmm_pkg::ROW_BITS-1:0]   row_index;
  logic [pmm_pkg::ROW_BITS-1:0]   col_index;

  modport source (output valid, kind, call_value, last_call, site_kept, row_index,
                  col_index, input ready);
  modport sink   (input valid, kind, call_value, last_call, site_kept, row_index,
                  col_index, output ready);
endinterface

interface pmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmm_pkg::OUT_BITS-1:0]  mismatch_count;
  logic [pmm_pkg::OUT_BITS-1:0]  nonmissing_count;

  modport source (output valid, mismatch_count, nonmissing_count, input ready);
  modport sink   (input valid, mismatch_count, nonmissing_count, output ready);
endinterface

interface pmm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pmm_pkg::CFG_BITS-1:0]  individual_count;

  modport source (output valid, individual_count, input ready);
  modport sink   (input valid, individual_count, output ready);
endinterface

// ===== design/pmm_ram.sv =====
// ----------------------------------------------------------------------------
// pmm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pmm_fifo.sv =====
// ----------------------------------------------------------------------------
// pmm_fifo: command queue between front end and back end
// Small register queue; the head entry is always presented.
// ----------------------------------------------------------------------------
module pmm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR = $clog2(DEPTH),
  localparam int CW  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR-1:0]   wr_ptr;
  logic [PTR-1:0]   rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR'(DEPTH - 1)) ? '0 : wr_ptr + PTR'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR'(DEPTH - 1)) ? '0 : rd_ptr + PTR'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("command pushed into a full queue");

endmodule

// ===== design/pmm_front.sv =====
// ----------------------------------------------------------------------------
// pmm_front: item intake and classification
// Tracks the buffer slot of the next call and turns each item into a command.
// ----------------------------------------------------------------------------
module pmm_front #(
  parameter int MAX_INDIVIDUALS = 64,
  localparam int IW    = $clog2(MAX_INDIVIDUALS),
  localparam int PW    = $clog2(MAX_INDIVIDUALS + 1),
  localparam int AW    = $clog2(MAX_INDIVIDUALS * MAX_INDIVIDUALS),
  localparam int CMD_W = 1 + pmm_pkg::CALL_BITS + 3 + IW + AW
) (
  input  logic             clk,
  input  logic             rst,
  pmm_in_if.sink           item,
  input  logic             clearing,
  input  logic             fifo_full,
  output logic             push,
  output logic [CMD_W-1:0] cmd_data
);

  typedef struct packed {
    pmm_pkg::op_t                  op;
    logic [pmm_pkg::CALL_BITS-1:0] value;
    logic                          store;
    logic                          sweep;
    logic [IW-1:0]                 slot;
    logic [AW-1:0]                 addr;
    logic                          in_range;
  } cmd_t;

  logic [PW-1:0] pos;
  logic          is_call;
  logic          slot_free;
  cmd_t          cmd;

  assign item.ready = !fifo_full && !clearing;
  assign push       = item.valid && item.ready;
  assign is_call    = (item.kind == pmm_pkg::KIND_CALL);
  assign slot_free  = (pos < PW'(MAX_INDIVIDUALS));

  // Classify the item into a command
  always_comb begin
    cmd.op       = is_call ? pmm_pkg::OP_CALL : pmm_pkg::OP_READ;
    cmd.value    = item.call_value;
    cmd.store    = is_call && slot_free;
    cmd.sweep    = is_call && item.last_call && item.site_kept;
    cmd.slot     = pos[IW-1:0];
    cmd.addr     = AW'(32'(item.row_index) * MAX_INDIVIDUALS + 32'(item.col_index));
    cmd.in_range = (32'(item.row_index) < MAX_INDIVIDUALS) &&
                   (32'(item.col_index) < MAX_INDIVIDUALS);
  end

  assign cmd_data = cmd;

  // Advance the call slot; return to zero after the last call of a site
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push && is_call) begin
      if (item.last_call) begin
        pos <= '0;
      end else if (slot_free) begin
        pos <= pos + PW'(1);
      end
    end
  end

  a_no_intake_clear: assert property (@(posedge clk) disable iff (rst)
      clearing |-> !item.ready)
    else $error("item taken during counter clearing");

endmodule

// ===== design/pmm_back.sv =====
// ----------------------------------------------------------------------------
// pmm_back: command execution
// Clears the counters after reset, stores calls, sweeps all pairs of a kept
// site through a read-modify-write pipeline, and serves counter reads.
// ----------------------------------------------------------------------------
module pmm_back #(
  parameter int MAX_INDIVIDUALS = 64,
  parameter int COUNTER_BITS    = 32,
  localparam int IW    = $clog2(MAX_INDIVIDUALS),
  localparam int NW    = $clog2(MAX_INDIVIDUALS + 1),
  localparam int DEPTH = MAX_INDIVIDUALS * MAX_INDIVIDUALS,
  localparam int AW    = $clog2(DEPTH),
  localparam int CMD_W = 1 + pmm_pkg::CALL_BITS + 3 + IW + AW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [NW-1:0]    n_eff,
  input  logic             fifo_empty,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             pop,
  output logic             clearing,
  pmm_out_if.source        result
);

  typedef struct packed {
    pmm_pkg::op_t                  op;
    logic [pmm_pkg::CALL_BITS-1:0] value;
    logic                          store;
    logic                          sweep;
    logic [IW-1:0]                 slot;
    logic [AW-1:0]                 addr;
    logic                          in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ
  } state_t;

  localparam int CB = COUNTER_BITS;
  localparam int OB = pmm_pkg::OUT_BITS;

  state_t  state;
  cmd_t    cmd;

  logic [AW-1:0] clr_addr;
  logic [IW-1:0] i_idx;
  logic [IW-1:0] j_idx;
  logic [AW-1:0] row_base;
  logic [NW-1:0] n_last;
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic          rd_zero;

  logic          out_valid;
  logic [OB-1:0] out_mism;
  logic [OB-1:0] out_nonm;

  logic                          site_we;
  logic                          site_re;
  logic [pmm_pkg::CALL_BITS-1:0] call_a;
  logic [pmm_pkg::CALL_BITS-1:0] call_b;

  logic            cnt_we;
  logic [AW-1:0]   cnt_waddr;
  logic [2*CB-1:0] cnt_wdata;
  logic            cnt_re;
  logic [AW-1:0]   cnt_raddr;
  logic [2*CB-1:0] cnt_rdata;
  logic [CB-1:0]   cnt_mism;
  logic [CB-1:0]   cnt_nonm;
  logic [CB-1:0]   mism_new;
  logic [CB-1:0]   nonm_new;
  logic            pair_called;
  logic [OB-1:0]   mism_out;
  logic [OB-1:0]   nonm_out;

  assign cmd      = cmd_t'(cmd_data);
  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !fifo_empty;
  assign n_last   = n_eff - NW'(1);

  // Site buffer, one copy per pair member
  assign site_we = pop && (cmd.op == pmm_pkg::OP_CALL) && cmd.store;
  assign site_re = (state == ST_SWEEP);

  pmm_ram #(.WIDTH(pmm_pkg::CALL_BITS), .DEPTH(MAX_INDIVIDUALS)) u_site_a (
    .clk   (clk),
    .we    (site_we),
    .waddr (cmd.slot),
    .wdata (cmd.value),
    .re    (site_re),
    .raddr (i_idx),
    .rdata (call_a)
  );

  pmm_ram #(.WIDTH(pmm_pkg::CALL_BITS), .DEPTH(MAX_INDIVIDUALS)) u_site_b (
    .clk   (clk),
    .we    (site_we),
    .waddr (cmd.slot),
    .wdata (cmd.value),
    .re    (site_re),
    .raddr (j_idx),
    .rdata (call_b)
  );

  // Counter update: both calls present adds to nonmissing, differing adds to mismatch
  assign cnt_mism    = cnt_rdata[2*CB-1:CB];
  assign cnt_nonm    = cnt_rdata[CB-1:0];
  assign pair_called = (call_a < pmm_pkg::MISSING_CODE) && (call_b < pmm_pkg::MISSING_CODE);
  assign nonm_new    = (&cnt_nonm) ? cnt_nonm : cnt_nonm + CB'(1);
  assign mism_new    = ((call_a != call_b) && !(&cnt_mism)) ? cnt_mism + CB'(1) : cnt_mism;

  // Counter RAM port selection
  always_comb begin
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else begin
      cnt_we    = s1_valid && pair_called;
      cnt_waddr = s1_addr;
      cnt_wdata = {mism_new, nonm_new};
    end
    if (state == ST_SWEEP) begin
      cnt_re    = 1'b1;
      cnt_raddr = row_base + AW'(j_idx);
    end else begin
      cnt_re    = pop && (cmd.op == pmm_pkg::OP_READ) && cmd.in_range;
      cnt_raddr = cmd.addr;
    end
  end

  pmm_ram #(.WIDTH(2 * CB), .DEPTH(DEPTH)) u_counters (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Limit counters to the output width
  if (CB > OB) begin : g_clamp
    assign mism_out = (|cnt_mism[CB-1:OB]) ? '1 : cnt_mism[OB-1:0];
    assign nonm_out = (|cnt_nonm[CB-1:OB]) ? '1 : cnt_nonm[OB-1:0];
  end else begin : g_extend
    assign mism_out = OB'(cnt_mism);
    assign nonm_out = OB'(cnt_nonm);
  end

  assign result.valid            = out_valid;
  assign result.mismatch_count   = out_mism;
  assign result.nonmissing_count = out_nonm;

  // Sequencer, sweep counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_SWEEP);
      s1_addr  <= row_base + AW'(j_idx);
      // Load a new result in the read state, drop the old one once taken
      if ((state == ST_READ) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            if (cmd.op == pmm_pkg::OP_READ) begin
              rd_zero <= !cmd.in_range;
              state   <= ST_READ;
            end else if (cmd.sweep) begin
              i_idx    <= '0;
              j_idx    <= '0;
              row_base <= '0;
              state    <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (NW'(j_idx) == n_last) begin
            j_idx    <= '0;
            i_idx    <= i_idx + IW'(1);
            row_base <= row_base + AW'(MAX_INDIVIDUALS);
            if (NW'(i_idx) == n_last) begin
              state <= ST_DRAIN;
            end
          end else begin
            j_idx <= j_idx + IW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          if (!out_valid || result.ready) begin
            out_mism  <= rd_zero ? '0 : mism_out;
            out_nonm  <= rd_zero ? '0 : nonm_out;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
      state == ST_IDLE |-> !s1_valid)
    else $error("pair update still in flight when taking a new command");

  a_no_rmw_hazard: assert property (@(posedge clk) disable iff (rst)
      cnt_we && cnt_re |-> cnt_waddr != cnt_raddr)
    else $error("counter read and write hit the same pair");

  a_read_data_held: assert property (@(posedge clk) disable iff (rst)
      state == ST_READ && $past(state) == ST_READ |-> $stable(cnt_rdata))
    else $error("counter read data changed while result waits");

endmodule

// ===== design/pairwise_mismatch_matrix.sv =====
// ----------------------------------------------------------------------------
// pairwise_mismatch_matrix: per-pair mismatch and coverage counters
// Accumulates, over kept sites, mismatch and nonmissing counts for every
// ordered pair of individuals and reads them back one pair per item.
// ----------------------------------------------------------------------------
// Usage:
//   item   : call items (kind 0) deliver one individual's base per item; the
//            call with last_call closes the site, and site_kept starts the
//            pair sweep. Read items (kind 1) ask for the pair (row, col).
//   result : one item per read, holding both counters of the pair.
//   cfg    : writes individual_count (N); write only while the block is idle.
// Timing:
//   A kept site sweeps N*N pairs at one pair per cycle through the counter RAM.
//   A read's result passes through the command queue, the registered counter
//   RAM read and the output register.
// Reset: the counter RAM is cleared one pair per cycle, all
//   MAX_INDIVIDUALS*MAX_INDIVIDUALS pairs; no item is accepted until done.
// Stall: a stalled result holds in the output register; a four-entry command
//   queue keeps accepting items until it fills.
// ----------------------------------------------------------------------------
module pairwise_mismatch_matrix #(
  parameter int MAX_INDIVIDUALS = 64,
  parameter int COUNTER_BITS    = 32
) (
  input  logic       clk,
  input  logic       rst,
  pmm_in_if.sink     item,
  pmm_out_if.source  result,
  pmm_cfg_if.sink    cfg
);

  localparam int IW    = $clog2(MAX_INDIVIDUALS);
  localparam int NW    = $clog2(MAX_INDIVIDUALS + 1);
  localparam int AW    = $clog2(MAX_INDIVIDUALS * MAX_INDIVIDUALS);
  localparam int CMD_W = 1 + pmm_pkg::CALL_BITS + 3 + IW + AW;

  logic [pmm_pkg::CFG_BITS-1:0] individual_count;
  logic [NW-1:0]                n_eff;
  logic                         clearing;
  logic                         push;
  logic                         pop;
  logic                         fifo_full;
  logic                         fifo_empty;
  logic [CMD_W-1:0]             push_data;
  logic [CMD_W-1:0]             head_data;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      individual_count <= pmm_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      individual_count <= cfg.individual_count;
    end
  end

  // Effective individual count: zero acts as one, limit to the buffer size
  always_comb begin
    if (individual_count == '0) begin
      n_eff = NW'(1);
    end else if (32'(individual_count) > MAX_INDIVIDUALS) begin
      n_eff = NW'(MAX_INDIVIDUALS);
    end else begin
      n_eff = NW'(individual_count);
    end
  end

  pmm_front #(.MAX_INDIVIDUALS(MAX_INDIVIDUALS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .clearing  (clearing),
    .fifo_full (fifo_full),
    .push      (push),
    .cmd_data  (push_data)
  );

  pmm_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_data),
    .pop     (pop),
    .rd_data (head_data),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  pmm_back #(.MAX_INDIVIDUALS(MAX_INDIVIDUALS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .n_eff      (n_eff),
    .fifo_empty (fifo_empty),
    .cmd_data   (head_data),
    .pop        (pop),
    .clearing   (clearing),
    .result     (result)
  );

endmodule

// ===== tb/tb_pairwise_mismatch_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_mismatch_matrix: self-checking bench for the pair counter matrix
// Feeds sites of base calls and pair reads through the item channel, keeps a
// shadow copy of the site buffer and both counter matrices, and compares
// every read result against it. Sweeps the individual count across its
// extremes with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_pairwise_mismatch_matrix;

  localparam int          MAX_IND      = 64;
  localparam int          CNT_BITS     = 32;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          PHASES       = 8;
  localparam logic [2:0]  MISSING_BASE = 3'd4;

  typedef struct packed {
    logic                          kind;
    logic [pmm_pkg::CALL_BITS-1:0] call_value;
    logic                          last_call;
    logic                          site_kept;
    logic [pmm_pkg::ROW_BITS-1:0]  row_index;
    logic [pmm_pkg::ROW_BITS-1:0]  col_index;
  } item_t;

  typedef struct packed {
    logic [pmm_pkg::OUT_BITS-1:0] mm;
    logic [pmm_pkg::OUT_BITS-1:0] nm;
  } count_pair_t;

  // Directed row: item, whether the counts are typed in, and those counts
  typedef struct packed {
    item_t                        it;
    logic                         lit;
    logic [pmm_pkg::OUT_BITS-1:0] mm;
    logic [pmm_pkg::OUT_BITS-1:0] nm;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  pmm_in_if  item_if ();
  pmm_out_if res_if ();
  pmm_cfg_if cfg_if ();

  pairwise_mismatch_matrix #(
    .MAX_INDIVIDUALS(MAX_IND),
    .COUNTER_BITS   (CNT_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_if),
    .result(res_if),
    .cfg   (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow state of the block
  logic [pmm_pkg::CFG_BITS-1:0] n_reg = pmm_pkg::CFG_RESET;
  logic [2:0]                   site_base [MAX_IND];
  bit                           site_seen [MAX_IND];
  int                           fill_pos = 0;
  logic [CNT_BITS-1:0]          mm_tab [MAX_IND*MAX_IND];
  logic [CNT_BITS-1:0]          nm_tab [MAX_IND*MAX_IND];

  count_pair_t pending_counts [$];
  count_pair_t got_pair;
  int          fail_count  = 0;
  int          idle_cycles = 0;
  bit          calm        = 1'b0;
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;

  // N = 3 after the write that precedes this table
  dir_row_t dir_tab [27] = '{
    // fresh counters read back zero, row and column extremes
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd0},  1'b1, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd7, 1'b1, 1'b1, 6'd63, 6'd63}, 1'b1, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd21, 6'd42}, 1'b1, 32'd0, 32'd0},
    // kept site A C T: every pair called, off-diagonal pairs differ
    '{'{pmm_pkg::KIND_CALL, 3'd0, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd1, 1'b0, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd3, 1'b1, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd0},  1'b1, 32'd0, 32'd1},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd1},  1'b1, 32'd1, 32'd1},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd2,  6'd1},  1'b1, 32'd1, 32'd1},
    // discarded site leaves the counters alone
    '{'{pmm_pkg::KIND_CALL, 3'd2, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd2, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd2, 1'b1, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd1,  6'd1},  1'b1, 32'd0, 32'd1},
    // missing and out-of-range call codes count as missing
    '{'{pmm_pkg::KIND_CALL, 3'd2, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd4, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd5, 1'b1, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd0},  1'b1, 32'd0, 32'd2},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd1,  6'd1},  1'b1, 32'd0, 32'd1},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd2},  1'b1, 32'd1, 32'd1},
    // short site reuses the older calls of the unwritten slots
    '{'{pmm_pkg::KIND_CALL, 3'd3, 1'b1, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd7, 1'b1, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    // long site: the call past N is stored but takes no part
    '{'{pmm_pkg::KIND_CALL, 3'd1, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd6, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd7, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_CALL, 3'd0, 1'b1, 1'b1, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd0},  1'b0, 32'd0, 32'd0},
    '{'{pmm_pkg::KIND_READ, 3'd0, 1'b0, 1'b0, 6'd0,  6'd1},  1'b0, 32'd0, 32'd0}
  };

  // N as the block uses it
  function automatic int eff_n();
    if (n_reg == 0) return 1;
    if (n_reg > MAX_IND) return MAX_IND;
    return int'(n_reg);
  endfunction

  function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
    return (v == '1) ? v : v + CNT_BITS'(1);
  endfunction

  // Add one kept site to every called pair of the first N individuals
  function automatic void tally_site();
    int n;
    int k;
    n = eff_n();
    for (int i = 0; i < n; i++) begin
      if (site_base[i] < MISSING_BASE) begin
        for (int j = 0; j < n; j++) begin
          if (site_base[j] < MISSING_BASE) begin
            k = i * MAX_IND + j;
            nm_tab[k] = bump(nm_tab[k]);
            if (site_base[i] != site_base[j]) mm_tab[k] = bump(mm_tab[k]);
          end
        end
      end
    end
  endfunction

  // A kept close may only read slots written at some time since reset
  function automatic bit site_closable();
    for (int s = 0; s < eff_n(); s++) begin
      if (!site_seen[s] && !(s == fill_pos && fill_pos < MAX_IND)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow state by one accepted item
  function automatic void absorb_item(item_t it, bit lit,
                                      logic [pmm_pkg::OUT_BITS-1:0] lit_mm,
                                      logic [pmm_pkg::OUT_BITS-1:0] lit_nm);
    count_pair_t want;
    int          k;
    if (it.kind == pmm_pkg::KIND_READ) begin
      k = int'(it.row_index) * MAX_IND + int'(it.col_index);
      want.mm = lit ? lit_mm : mm_tab[k];
      want.nm = lit ? lit_nm : nm_tab[k];
      pending_counts.push_back(want);
    end else begin
      if (fill_pos < MAX_IND) begin
        site_base[fill_pos] = it.call_value;
        site_seen[fill_pos] = 1'b1;
        fill_pos++;
      end
      if (it.last_call) begin
        if (it.site_kept) tally_site();
        fill_pos = 0;
      end
    end
  endfunction

  // Offer one item, with an occasional gap ahead of it
  task automatic send_item(item_t it, bit lit, logic [pmm_pkg::OUT_BITS-1:0] lit_mm,
                           logic [pmm_pkg::OUT_BITS-1:0] lit_nm);
    if (!calm && $urandom_range(99) < 9) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    item_if.kind       <= it.kind;
    item_if.call_value <= it.call_value;
    item_if.last_call  <= it.last_call;
    item_if.site_kept  <= it.site_kept;
    item_if.row_index  <= it.row_index;
    item_if.col_index  <= it.col_index;
    item_if.valid      <= 1'b1;
    do @(posedge clk); while (!(item_if.valid && item_if.ready));
    absorb_item(it, lit, lit_mm, lit_nm);
    @(negedge clk);
  endtask

  // Random pair read, mostly inside the active N, with junk in the call fields
  task automatic send_read();
    item_t it;
    it.kind       = pmm_pkg::KIND_READ;
    it.call_value = pmm_pkg::CALL_BITS'($urandom_range(7));
    it.last_call  = 1'($urandom_range(1));
    it.site_kept  = 1'($urandom_range(1));
    if ($urandom_range(99) < 60) begin
      it.row_index = pmm_pkg::ROW_BITS'($urandom_range(eff_n() - 1));
      it.col_index = pmm_pkg::ROW_BITS'($urandom_range(eff_n() - 1));
    end else begin
      it.row_index = pmm_pkg::ROW_BITS'($urandom_range(MAX_IND - 1));
      it.col_index = pmm_pkg::ROW_BITS'($urandom_range(MAX_IND - 1));
    end
    send_item(it, 1'b0, '0, '0);
  endtask

  task automatic write_count(logic [pmm_pkg::CFG_BITS-1:0] v);
    cfg_if.individual_count <= v;
    cfg_if.valid            <= 1'b1;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    n_reg = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid, drain all reads, then let a possible sweep finish
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (eff_n() * eff_n() + 16) @(posedge clk);
    @(negedge clk);
  endtask

  // Well-formed sites of random content, with short, long and dropped sites
  task automatic run_phase(int idx, int budget);
    item_t it;
    int    sent;
    int    len;
    int    roll;
    bit    paused;
    sent   = 0;
    paused = 1'b0;
    calm   = (idx == 4);
    // hold the result side while reads keep coming, so the queue backs up
    if (idx == 1) begin
      hold_req = 1'b1;
      repeat (40) send_read();
    end
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 10) len = $urandom_range(eff_n(), 1);
      else if (roll < 18) len = eff_n() + $urandom_range(3, 1);
      else len = eff_n();
      for (int c = 0; c < len; c++) begin
        if ($urandom_range(99) < 25) begin
          send_read();
          sent++;
        end
        it.kind       = pmm_pkg::KIND_CALL;
        it.call_value = ($urandom_range(99) < 80)
                        ? pmm_pkg::CALL_BITS'($urandom_range(3))
                        : pmm_pkg::CALL_BITS'($urandom_range(7, 4));
        it.row_index  = pmm_pkg::ROW_BITS'($urandom_range(MAX_IND - 1));
        it.col_index  = pmm_pkg::ROW_BITS'($urandom_range(MAX_IND - 1));
        it.last_call  = (c == len - 1);
        if (it.last_call) it.site_kept = ($urandom_range(99) < 85) && site_closable();
        else it.site_kept = 1'($urandom_range(1));
        send_item(it, 1'b0, '0, '0);
        sent++;
      end
      // sender waits for every outstanding result once
      if (idx == 3 && !paused && sent > budget / 2) begin
        paused = 1'b1;
        item_if.valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        @(negedge clk);
      end
    end
    send_read();
    calm = 1'b0;
  endtask

  // Result side ready: random stalls, a long hold on request, none when calm
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (calm) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= 9);
    end
  end

  // Compare each result with the oldest expected pair
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_counts.size() == 0) begin
        $error("result with none expected: mismatch_count=%0d nonmissing_count=%0d",
               res_if.mismatch_count, res_if.nonmissing_count);
        fail_count++;
      end else begin
        got_pair = pending_counts.pop_front();
        if (res_if.mismatch_count !== got_pair.mm) begin
          $error("mismatch_count: expected %0d, actual %0d", got_pair.mm,
                 res_if.mismatch_count);
          fail_count++;
        end
        if (res_if.nonmissing_count !== got_pair.nm) begin
          $error("nonmissing_count: expected %0d, actual %0d", got_pair.nm,
                 res_if.nonmissing_count);
          fail_count++;
        end
      end
    end
  end

  // Stop the run when no channel moves for too long
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pairwise_mismatch_matrix failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [pmm_pkg::CFG_BITS-1:0] phase_n [PHASES];
    item_t                        it;
    phase_n = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd0, 7'd64, 7'd5};
    // one mid-range count, drawn per run
    phase_n[5] = pmm_pkg::CFG_BITS'($urandom_range(63, 3));

    rst                     = 1'b1;
    item_if.valid           = 1'b0;
    item_if.kind            = pmm_pkg::KIND_CALL;
    item_if.call_value      = '0;
    item_if.last_call       = 1'b0;
    item_if.site_kept       = 1'b0;
    item_if.row_index       = '0;
    item_if.col_index       = '0;
    res_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.individual_count = pmm_pkg::CFG_RESET;
    for (int k = 0; k < MAX_IND * MAX_IND; k++) begin
      mm_tab[k] = '0;
      nm_tab[k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table at N = 3
    write_count(7'd3);
    for (int r = 0; r < $size(dir_tab); r++) begin
      it = dir_tab[r].it;
      send_item(it, dir_tab[r].lit, dir_tab[r].mm, dir_tab[r].nm);
    end
    settle();

    // random phases across the count settings
    for (int p = 0; p < PHASES; p++) begin
      write_count(phase_n[p]);
      run_phase(p, PHASE_ITEMS);
      settle();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("tb_pairwise_mismatch_matrix passed");
    end else begin
      $display("tb_pairwise_mismatch_matrix failed");
    end
    $finish;
  end

endmodule
